// ===== rtl/core/mixed_radix_index_converter_defines.svh =====
// Assertion macros used by the converter top level, which checks itself.
`ifndef MIXED_RADIX_INDEX_CONVERTER_DEFINES_SVH
`define MIXED_RADIX_INDEX_CONVERTER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define MRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define MRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mrc_pkg.sv =====
`timescale 1ns / 1ps
package mrc_pkg;

  localparam int unsigned NumPos    = 6;
  localparam int unsigned MaxDigits = 6;
  localparam int unsigned ValW      = 32;
  localparam int unsigned DigW      = 8;
  localparam int unsigned ChunkW    = 8;
  localparam int unsigned NumSub    = ValW / ChunkW;

  localparam logic [2:0] RegDigitCount = 3'd0;
  localparam logic [2:0] RegRadix0     = 3'd1;
  localparam logic [2:0] RegRadixLast  = 3'(NumPos);

  localparam logic ActEncode = 1'b0;
  localparam logic ActDecode = 1'b1;

  typedef logic [NumPos-1:0][DigW-1:0] byte_arr_t;

  typedef struct packed {
    logic              action;
    logic [ValW-1:0]   value;
    logic [ValW-1:0]   acc;
    logic [DigW-1:0]   rem;
    logic              ovf;
    byte_arr_t         dig;
  } item_t;

  typedef struct packed {
    logic [DigW-1:0] rem;
    logic [DigW-1:0] quo;
  } div_res_t;

  // Eight restoring division steps: a remainder below the divisor takes in
  // eight more dividend bits and yields eight quotient bits.
  function automatic div_res_t div_step(input logic [DigW-1:0] rem,
                                        input logic [ChunkW-1:0] bits,
                                        input logic [DigW-1:0] dv);
    div_res_t     res;
    logic [DigW:0] t;
    res.rem = rem;
    res.quo = '0;
    for (int b = ChunkW - 1; b >= 0; b--) begin
      t = {res.rem, bits[b]};
      if (t >= {1'b0, dv}) begin
        t = t - {1'b0, dv};
        res.quo[b] = 1'b1;
      end
      res.rem = t[DigW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/mrc_in_if.sv =====
`timescale 1ns / 1ps
interface mrc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] flat_number;
  logic [7:0]  in_digit_0;
  logic [7:0]  in_digit_1;
  logic [7:0]  in_digit_2;
  logic [7:0]  in_digit_3;
  logic [7:0]  in_digit_4;
  logic [7:0]  in_digit_5;

  modport source (output valid, action, flat_number, in_digit_0, in_digit_1, in_digit_2,
                  in_digit_3, in_digit_4, in_digit_5, input ready);
  modport sink (input valid, action, flat_number, in_digit_0, in_digit_1, in_digit_2,
                in_digit_3, in_digit_4, in_digit_5, output ready);
endinterface

// ===== rtl/core/mrc_out_if.sv =====
`timescale 1ns / 1ps
interface mrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] encoded_number;
  logic [7:0]  out_digit_0;
  logic [7:0]  out_digit_1;
  logic [7:0]  out_digit_2;
  logic [7:0]  out_digit_3;
  logic [7:0]  out_digit_4;
  logic [7:0]  out_digit_5;
  logic        leading_overflow;

  modport source (output valid, encoded_number, out_digit_0, out_digit_1, out_digit_2,
                  out_digit_3, out_digit_4, out_digit_5, leading_overflow, input ready);
  modport sink (input valid, encoded_number, out_digit_0, out_digit_1, out_digit_2,
                out_digit_3, out_digit_4, out_digit_5, leading_overflow, output ready);
endinterface

// ===== rtl/core/mrc_cell.sv =====
`timescale 1ns / 1ps
module mrc_cell import mrc_pkg::*; #(
  parameter int unsigned CellIdx = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [2:0] cnt_i,
  input  byte_arr_t  radix_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  item_t      in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output item_t      out_item_o
);

  localparam logic [2:0] Idx = 3'(CellIdx);

  // Encode works on position CellIdx, decode on the position counted from
  // the least significant end.
  logic            active;
  logic            is_lead;
  logic [2:0]      pos;
  logic [DigW-1:0] rsel;
  logic [DigW-1:0] divisor;

  assign active  = Idx < cnt_i;
  assign pos     = cnt_i - 3'd1 - Idx;
  assign is_lead = (pos == 3'd0);
  assign rsel    = radix_i[pos];
  assign divisor = (rsel == '0) ? DigW'(1) : rsel;

  logic  valid_q [NumSub];
  item_t data_q  [NumSub];
  item_t stage_in  [NumSub];
  item_t stage_out [NumSub];
  logic  vin [NumSub];
  logic  rdy [NumSub+1];

  assign rdy[NumSub] = out_ready_i;
  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NumSub-1];
  assign out_item_o  = data_q[NumSub-1];

  for (genvar s = 0; s < NumSub; s++) begin : g_sub
    localparam int unsigned ValTop = ValW - 1 - s * ChunkW;

    logic [DigW-1:0] rem_in;
    div_res_t        dr;
    item_t           it;

    if (s == 0) begin : g_first
      assign stage_in[s] = in_item_i;
      assign vin[s]      = in_valid_i;
    end else begin : g_next
      assign stage_in[s] = data_q[s-1];
      assign vin[s]      = valid_q[s-1];
    end

    assign rdy[s] = !valid_q[s] || rdy[s+1];
    assign rem_in = (s == 0) ? '0 : stage_in[s].rem;
    assign dr     = div_step(rem_in, stage_in[s].value[ValTop -: ChunkW], divisor);

    always_comb begin
      it = stage_in[s];
      if (active) begin
        if (it.action == ActEncode) begin
          if (s == 0) begin
            it.acc = 32'(it.acc * radix_i[CellIdx]) + {24'd0, it.dig[CellIdx]};
          end
        end else if (is_lead) begin
          if (s == 0) begin
            if (|it.value[ValW-1:DigW]) begin
              it.dig[0] = '1;
              it.ovf    = 1'b1;
            end else begin
              it.dig[0] = it.value[DigW-1:0];
            end
          end
        end else begin
          it.rem = dr.rem;
          it.value[ValTop -: ChunkW] = dr.quo;
          if (s == NumSub - 1) begin
            it.dig[pos] = dr.rem;
          end
        end
      end
      stage_out[s] = it;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid_q[s] <= vin[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && vin[s]) begin
        data_q[s] <= stage_out[s];
      end
    end
  end

endmodule

// ===== rtl/core/mixed_radix_index_converter.sv =====
`timescale 1ns / 1ps
// Mixed-radix index converter. Takes one beat per clock while the output
// is not stalled and returns one result beat per input beat, in order.
// The block is a row of MAX_DIGITS cells, one per digit position; each
// cell divides a 32-bit value by an 8-bit radix eight quotient bits per
// stage, so a cell is four registered stages deep, and that byte-serial
// division sets the depth of each cell. Encode (action 0) runs a
// Horner multiply-add in the first stage of each cell, most significant
// digit first, modulo 2^32. Decode (action 1) peels digits off from the
// least significant end; the last active cell takes what is left as the
// leading digit, saturating at 255 with leading_overflow set. A zero radix
// is used as is in encode and treated as one in decode. Configuration
// (digit_count at index 0, radix_0..radix_5 at indexes 1..6) must be
// written only while the pipeline is empty. Every stage has its own valid
// and ready, so bubbles close up and new beats enter while a finished
// result waits at the output.
module mixed_radix_index_converter import mrc_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MaxDigits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  mrc_in_if.sink     in_i,
  mrc_out_if.source  out_o
);

`include "mixed_radix_index_converter_defines.svh"

  logic [2:0] digit_count_q;
  byte_arr_t  radix_q;
  logic [2:0] cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= 3'd6;
      radix_q       <= {NumPos{8'd2}};
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegDigitCount) begin
        digit_count_q <= cfg_data_i[2:0];
      end else if (cfg_idx_i >= RegRadix0 && cfg_idx_i <= RegRadixLast) begin
        radix_q[3'(cfg_idx_i - RegRadix0)] <= cfg_data_i;
      end
    end
  end

  // Active digit count, limited to the number of cells.
  assign cnt = (digit_count_q > 3'(MAX_DIGITS)) ? 3'(MAX_DIGITS) : digit_count_q;

  logic  ch_valid [MAX_DIGITS+1];
  logic  ch_ready [MAX_DIGITS+1];
  item_t ch_item  [MAX_DIGITS+1];

  // Decode starts from cleared digits so inactive positions read as zero.
  always_comb begin
    ch_item[0].action = in_i.action;
    ch_item[0].value  = in_i.flat_number;
    ch_item[0].acc    = '0;
    ch_item[0].rem    = '0;
    ch_item[0].ovf    = 1'b0;
    if (in_i.action == ActDecode) begin
      ch_item[0].dig = '0;
    end else begin
      ch_item[0].dig = {in_i.in_digit_5, in_i.in_digit_4, in_i.in_digit_3,
                        in_i.in_digit_2, in_i.in_digit_1, in_i.in_digit_0};
    end
  end

  assign ch_valid[0] = in_i.valid;
  assign in_i.ready  = ch_ready[0];

  for (genvar c = 0; c < MAX_DIGITS; c++) begin : g_cell
    mrc_cell #(.CellIdx(c)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cnt_i      (cnt),
      .radix_i    (radix_q),
      .in_valid_i (ch_valid[c]),
      .in_ready_o (ch_ready[c]),
      .in_item_i  (ch_item[c]),
      .out_valid_o(ch_valid[c+1]),
      .out_ready_i(ch_ready[c+1]),
      .out_item_o (ch_item[c+1])
    );
  end

  item_t fin;
  logic  dec;

  assign fin = ch_item[MAX_DIGITS];
  assign dec = (fin.action == ActDecode);

  assign out_o.valid            = ch_valid[MAX_DIGITS];
  assign ch_ready[MAX_DIGITS]   = out_o.ready;
  assign out_o.encoded_number   = dec ? '0 : fin.acc;
  assign out_o.out_digit_0      = dec ? fin.dig[0] : '0;
  assign out_o.out_digit_1      = dec ? fin.dig[1] : '0;
  assign out_o.out_digit_2      = dec ? fin.dig[2] : '0;
  assign out_o.out_digit_3      = dec ? fin.dig[3] : '0;
  assign out_o.out_digit_4      = dec ? fin.dig[4] : '0;
  assign out_o.out_digit_5      = dec ? fin.dig[5] : '0;
  assign out_o.leading_overflow = dec & fin.ovf;

  // A stalled input means every stage holds a beat, so a result is waiting.
  `MRC_ASSERT_IMPL(a_stall_full, !in_i.ready, out_o.valid, "input stalled with empty output")
  // Overflow only comes from decode, where the leading digit saturates.
  `MRC_ASSERT_IMPL(a_ovf_sat, out_o.valid && out_o.leading_overflow,
                   out_o.out_digit_0 == 8'hFF && out_o.encoded_number == 32'd0,
                   "overflow without saturated leading digit")
  // A result held back by the sink keeps its value.
  `MRC_ASSERT_NEXT(a_out_hold, out_o.valid && !out_o.ready,
                   out_o.valid && $stable(out_o.encoded_number),
                   "stalled result changed")

endmodule
